FILE: sv/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// shared widths, types and the lead byte classifier for the utf-8 decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned PendW = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CpW-1:0]   cp_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [PendW-1:0] pend_t;

  localparam len_t LenOne   = 3'd1;
  localparam len_t LenTwo   = 3'd2;
  localparam len_t LenThree = 3'd3;
  localparam len_t LenFour  = 3'd4;

  // range limits for the checked forms
  localparam cp_t MinTwo     = 21'h00080;
  localparam cp_t MinThree   = 21'h00800;
  localparam cp_t MinFour    = 21'h10000;
  localparam cp_t MaxCp      = 21'h10FFFF;
  localparam cp_t SurrLo     = 21'h0D800;
  localparam cp_t SurrHi     = 21'h0DFFF;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_e;

  // payload of a lead byte once classified
  typedef struct packed {
    lead_class_e cls;
    cp_t         value;
    pend_t       pend;
    len_t        len;
  } lead_t;

  function automatic lead_t lead_decode(byte_t b);
    lead_t r;
    r.cls   = LEAD_BAD;
    r.value = '0;
    r.pend  = '0;
    r.len   = LenOne;
    unique casez (b)
      8'b0???????: begin
        r.cls   = LEAD_ASCII;
        r.value = {{(CpW-ByteW){1'b0}}, b};
      end
      8'b110?????: begin
        r.cls   = LEAD_TWO;
        r.value = {{(CpW-5){1'b0}}, b[4:0]};
        r.pend  = 2'd1;
        r.len   = LenTwo;
      end
      8'b1110????: begin
        r.cls   = LEAD_THREE;
        r.value = {{(CpW-4){1'b0}}, b[3:0]};
        r.pend  = 2'd2;
        r.len   = LenThree;
      end
      8'b11110???: begin
        r.cls   = LEAD_FOUR;
        r.value = {{(CpW-3){1'b0}}, b[2:0]};
        r.pend  = 2'd3;
        r.len   = LenFour;
      end
      default: begin
        r.cls = LEAD_BAD;
      end
    endcase
    return r;
  endfunction

  // overlong, surrogate or out of range for the given length
  function automatic logic range_bad(cp_t cp, len_t len);
    logic bad;
    case (len)
      LenTwo:   bad = (cp < MinTwo);
      LenThree: bad = (cp < MinThree) || ((cp >= SurrLo) && (cp <= SurrHi));
      default:  bad = (cp < MinFour) || (cp > MaxCp);
    endcase
    return bad;
  endfunction

endpackage

FILE: sv/u8d_byte_if.sv
// ----------------------------------------------------------------------------
// u8d_byte_if
// byte channel: one raw text byte per word
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

FILE: sv/u8d_cp_if.sv
// ----------------------------------------------------------------------------
// u8d_cp_if
// codepoint channel: one decoded codepoint per word
// ----------------------------------------------------------------------------
interface u8d_cp_if;
  logic                     valid;
  logic                     ready;
  logic [u8d_pkg::CpW-1:0]  codepoint;
  logic [u8d_pkg::LenW-1:0] seq_length;
  logic                     error;

  modport source (output valid, output codepoint, output seq_length, output error,
                  input ready);
  modport sink (input valid, input codepoint, input seq_length, input error,
                output ready);
endinterface

FILE: sv/u8d_cfg_if.sv
// ----------------------------------------------------------------------------
// u8d_cfg_if
// configuration write channel for the check enable register
// ----------------------------------------------------------------------------
interface u8d_cfg_if;
  logic valid;
  logic ready;
  logic check_enable;

  modport source (output valid, output check_enable, input ready);
  modport sink (input valid, input check_enable, output ready);
endinterface

FILE: sv/u8d_in_stage.sv
// ----------------------------------------------------------------------------
// u8d_in_stage
// input register: holds one byte word between the port and the decode core
// ----------------------------------------------------------------------------
module u8d_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  u8d_byte_if.sink   byte_i,
  u8d_byte_if.source byte_o
);
  import u8d_pkg::*;

  logic  valid_q, valid_d;
  byte_t byte_q;
  logic  load;

  assign byte_i.ready = !valid_q || byte_o.ready;
  assign load         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (byte_i.ready) begin
      valid_d = byte_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i.byte_in;
    end
  end

  assign byte_o.valid   = valid_q;
  assign byte_o.byte_in = byte_q;

endmodule

FILE: sv/u8d_core.sv
// ----------------------------------------------------------------------------
// u8d_core
// sequence state, byte decode and result register
// ----------------------------------------------------------------------------
module u8d_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     check_en_i,
  u8d_byte_if.sink byte_i,
  u8d_cp_if.source cp_o
);
  import u8d_pkg::*;

  pend_t pend_q, pend_d;
  cp_t   part_q, part_d;
  len_t  size_q, size_d;

  logic  out_valid_q, out_valid_d;
  cp_t   cp_q, cp_d;
  len_t  len_q, len_d;
  logic  err_q, err_d;

  logic  take;
  logic  emit;
  lead_t lead;
  cp_t   part_app;
  pend_t pend_dec;

  assign byte_i.ready = !out_valid_q || cp_o.ready;
  assign take         = byte_i.valid && byte_i.ready;

  assign lead     = lead_decode(byte_i.byte_in);
  assign part_app = {part_q[CpW-7:0], byte_i.byte_in[5:0]};
  assign pend_dec = pend_q - 2'd1;

  always_comb begin
    pend_d = pend_q;
    part_d = part_q;
    size_d = size_q;
    emit   = 1'b0;
    cp_d   = part_app;
    len_d  = size_q;
    err_d  = 1'b0;
    if (pend_q == '0) begin
      case (lead.cls)
        LEAD_ASCII, LEAD_BAD: begin
          emit  = 1'b1;
          cp_d  = lead.value;
          len_d = LenOne;
          err_d = (lead.cls == LEAD_BAD);
        end
        default: begin
          part_d = lead.value;
          size_d = lead.len;
          pend_d = lead.pend;
        end
      endcase
    end else begin
      pend_d = pend_dec;
      part_d = part_app;
      if (pend_dec == '0) begin
        emit   = 1'b1;
        err_d  = check_en_i && range_bad(part_app, size_q);
        part_d = '0;
        size_d = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (byte_i.ready) begin
      out_valid_d = take && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      part_q      <= '0;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        pend_q <= pend_d;
        part_q <= part_d;
        size_q <= size_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      cp_q  <= cp_d;
      len_q <= len_d;
      err_q <= err_d;
    end
  end

  assign cp_o.valid      = out_valid_q;
  assign cp_o.codepoint  = cp_q;
  assign cp_o.seq_length = len_q;
  assign cp_o.error      = err_q;

  // open sequence always longer than what is still owed
  a_size_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != '0) |-> ({1'b0, pend_q} < size_q))
    else $error("sequence size not above pending count");

  // idle state keeps no partial sequence
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == '0) |-> ((size_q == '0) && (part_q == '0)))
    else $error("stale sequence state while idle");

  // single byte errors carry codepoint zero
  a_bad_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (len_q == LenOne) && err_q) |-> (cp_q == '0))
    else $error("invalid lead byte with non-zero codepoint");

  // a multi byte lead opens a sequence
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (pend_q == '0) && !emit) |=> (pend_q != '0))
    else $error("lead byte did not open a sequence");

endmodule

FILE: sv/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// streaming utf-8 decoder, one byte word in, one codepoint word per sequence
// ----------------------------------------------------------------------------
// Takes one byte per cycle on byte_i and returns one codepoint word on cp_o for
// each finished sequence (one word for an ascii byte, for an invalid lead byte,
// or on the last continuation byte). Continuation bytes are not checked for
// their marker bits; only the low six bits are used. An invalid lead byte
// gives codepoint 0, length 1 and error set. With check_enable set, overlong
// forms, surrogates and values above 0x10ffff also set error; the codepoint is
// still returned. Throughput is one byte per cycle while cp_o keeps taking
// words; an accepted byte passes the input register, then the decode step
// into the result register, before its codepoint word appears. A finished word
// left waiting on cp_o stops the decode step; the input register then takes at
// most one more byte, after which byte_i stalls until cp_o takes the word.
// check_enable resets to 1 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic     clk_i,
  input  logic     rst_ni,
  u8d_byte_if.sink byte_i,
  u8d_cp_if.source cp_o,
  u8d_cfg_if.sink  cfg_i
);
  import u8d_pkg::*;

  // check enable register, always writable
  logic check_en_q;

  // link between the input register and the decode core
  u8d_byte_if stage_if ();

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_en_q <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      check_en_q <= cfg_i.check_enable;
    end
  end

  // input register parts the port from the decode logic
  u8d_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .byte_o (stage_if.source)
  );

  // sequence state, decode and result register
  u8d_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .check_en_i (check_en_q),
    .byte_i     (stage_if.sink),
    .cp_o       (cp_o)
  );

endmodule
